// ===== hdl/pps_pkg.sv =====
// shared types, constants and helper functions of the trajectory sampler
// used by pps_ctrl, pps_datapath and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  localparam int MAX_COEFFS   = 10;
  localparam int MAX_SEGMENTS = 16;
  localparam int AXES         = 4;
  localparam int COEF_DEPTH   = MAX_SEGMENTS * AXES * MAX_COEFFS;
  localparam int ADDR_W       = $clog2(COEF_DEPTH);
  localparam int SEG_W        = 4;
  localparam int CNT_W        = 4;
  localparam int NSEG_W       = 5;
  localparam int DATA_W       = 48;
  localparam int TIME_W       = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [1:0] OP_LOAD_COEFF = 2'd0;
  localparam logic [1:0] OP_LOAD_DUR   = 2'd1;
  localparam logic [1:0] OP_START      = 2'd2;
  localparam logic [1:0] OP_SAMPLE     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd1;

  localparam logic [1:0] YAW_AXIS       = 2'd3;
  localparam logic [1:0] LAST_DERIV     = 2'd3;
  localparam logic [1:0] YAW_LAST_DERIV = 2'd1;

  localparam logic signed [DATA_W-1:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [DATA_W-1:0] NEG_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic              latch_in;
    logic              load_coeff;
    logic              load_dur;
    logic              sum_clear;
    logic              sum_add;
    logic              sum_done;
    logic              setup;
    logic              advance;
    logic              acc_clear;
    logic              rd_issue;
    logic              mul;
    logic              mt;
    logic              add;
    logic              store_deriv;
    logic              emit;
    logic              clr_we;
    logic [1:0]        axis;
    logic [1:0]        d;
    logic [CNT_W-1:0]  k;
    logic [SEG_W-1:0]  idx;
    logic [ADDR_W-1:0] clr_addr;
  } pps_cmd_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [CNT_W-1:0]  n;
    logic [NSEG_W-1:0] ns;
    logic              tracking;
    logic              out_busy;
  } pps_status_t;

  // product (k+1)..(k+d), the factor of coefficient k+d in derivative d
  function automatic logic [9:0] deriv_factor(input logic [CNT_W-1:0] k, input logic [1:0] d);
    logic [9:0] f;
    f = 10'd1;
    for (int j = 1; j <= 3; j++) begin
      if (j <= int'(d)) f = 10'(f * 10'(int'(k) + j));
    end
    return f;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat48(input logic signed [63:0] v);
    if (&v[63:47] || ~|v[63:47]) return v[47:0];
    return v[63] ? NEG_MIN : POS_MAX;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pps_ctrl.sv =====
// controller of the trajectory sampler: sequences loads, end time sum,
// horner steps and result requests; depends on pps_pkg
`timescale 1ns / 1ps
`default_nettype none

module pps_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  pps_pkg::pps_status_t  status,
  output pps_pkg::pps_cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SUM, S_SETUP, S_ADV, S_DSTART,
    S_RD, S_MUL, S_MT, S_ADD, S_DSTORE, S_EMIT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [1:0]                    axis_r, axis_nxt;
  logic [1:0]                    d_r, d_nxt;
  logic [pps_pkg::CNT_W-1:0]     k_r, k_nxt;
  logic [pps_pkg::NSEG_W-1:0]    idx_r, idx_nxt;
  logic [pps_pkg::ADDR_W-1:0]    clr_r, clr_nxt;
  logic [1:0]                    last_d;

  assign in_ready = (state_r == S_IDLE);
  assign last_d   = (axis_r == pps_pkg::YAW_AXIS) ? pps_pkg::YAW_LAST_DERIV
                                                  : pps_pkg::LAST_DERIV;

  always_comb begin
    state_nxt    = state_r;
    axis_nxt     = axis_r;
    d_nxt        = d_r;
    k_nxt        = k_r;
    idx_nxt      = idx_r;
    clr_nxt      = clr_r;
    cmd          = '0;
    cmd.axis     = axis_r;
    cmd.d        = d_r;
    cmd.k        = k_r;
    cmd.idx      = idx_r[pps_pkg::SEG_W-1:0];
    cmd.clr_addr = clr_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == pps_pkg::ADDR_W'(pps_pkg::COEF_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.opcode)
          pps_pkg::OP_LOAD_COEFF: begin
            cmd.load_coeff = 1'b1;
            state_nxt      = S_IDLE;
          end
          pps_pkg::OP_LOAD_DUR: begin
            cmd.load_dur = 1'b1;
            state_nxt    = S_IDLE;
          end
          pps_pkg::OP_START: begin
            cmd.sum_clear = 1'b1;
            idx_nxt       = '0;
            state_nxt     = S_SUM;
          end
          default: begin
            cmd.setup = 1'b1;
            state_nxt = S_SETUP;
          end
        endcase
      end
      S_SUM: begin
        if (idx_r < status.ns) begin
          cmd.sum_add = 1'b1;
          idx_nxt     = idx_r + 1'b1;
        end else begin
          cmd.sum_done = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SETUP: begin
        // tracking flag and local time are registered now
        axis_nxt  = '0;
        d_nxt     = '0;
        state_nxt = S_ADV;
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_nxt   = status.tracking ? S_DSTART : S_EMIT;
      end
      S_DSTART: begin
        cmd.acc_clear = 1'b1;
        if (status.n <= pps_pkg::CNT_W'(d_r)) begin
          state_nxt = S_DSTORE;
        end else begin
          k_nxt     = status.n - pps_pkg::CNT_W'(d_r) - 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MT;
      end
      S_MT: begin
        cmd.mt    = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (k_r == '0) begin
          state_nxt = S_DSTORE;
        end else begin
          k_nxt     = k_r - 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DSTORE: begin
        cmd.store_deriv = 1'b1;
        if (d_r == last_d) begin
          state_nxt = S_EMIT;
        end else begin
          d_nxt     = d_r + 1'b1;
          state_nxt = S_DSTART;
        end
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit = 1'b1;
          if (axis_r == pps_pkg::YAW_AXIS) begin
            state_nxt = S_IDLE;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            d_nxt     = '0;
            state_nxt = status.tracking ? S_DSTART : S_EMIT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      axis_r  <= '0;
      d_r     <= '0;
      k_r     <= '0;
      idx_r   <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      d_r     <= d_nxt;
      k_r     <= k_nxt;
      idx_r   <= idx_nxt;
      clr_r   <= clr_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pps_datapath.sv =====
// datapath of the trajectory sampler: coefficient memory, durations,
// config registers, horner unit and result register; depends on pps_pkg
`timescale 1ns / 1ps
`default_nettype none

module pps_datapath (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  pps_pkg::pps_cmd_t                          cmd,
  output pps_pkg::pps_status_t                       status,
  input  wire  [1:0]                                 in_opcode,
  input  wire  [pps_pkg::SEG_W-1:0]                  in_segment,
  input  wire  [1:0]                                 in_axis,
  input  wire  [pps_pkg::CNT_W-1:0]                  in_coeff_index,
  input  wire  signed [pps_pkg::DATA_W-1:0]          in_coeff_value,
  input  wire  [pps_pkg::TIME_W-1:0]                 in_time_value,
  input  wire                                        cfg_valid,
  input  wire  [pps_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  wire  [pps_pkg::CFG_DATA_W-1:0]             cfg_data,
  output logic                                       out_valid,
  input  wire                                        out_ready,
  output logic [1:0]                                 out_axis,
  output logic signed [pps_pkg::DATA_W-1:0]          out_position,
  output logic signed [pps_pkg::DATA_W-1:0]          out_velocity,
  output logic signed [pps_pkg::DATA_W-1:0]          out_acceleration,
  output logic signed [pps_pkg::DATA_W-1:0]          out_jerk_value,
  output logic                                       out_tracking,
  output logic                                       out_last_of_run
);

  localparam int DW = pps_pkg::DATA_W;
  localparam int TW = pps_pkg::TIME_W;
  localparam int AW = pps_pkg::ADDR_W;

  // latched request
  logic [1:0]                op_r;
  logic [pps_pkg::SEG_W-1:0] seg_r;
  logic [1:0]                ax_in_r;
  logic [pps_pkg::CNT_W-1:0] ci_r;
  logic signed [DW-1:0]      cv_r;
  logic [TW-1:0]             tv_r;

  logic [pps_pkg::CNT_W-1:0]  coeff_count_r;
  logic [pps_pkg::NSEG_W-1:0] segment_count_r;

  logic [TW-1:0]             dur_r [pps_pkg::MAX_SEGMENTS];
  logic [TW-1:0]             end_time_r, sst_r, sum_r, t_r;
  logic [pps_pkg::SEG_W-1:0] cur_r;
  logic                      tracking_r;
  logic signed [DW-1:0]      held_r [pps_pkg::AXES];
  logic signed [DW-1:0]      res_r [4];

  logic signed [DW-1:0]      coef_mem [pps_pkg::COEF_DEPTH];
  logic signed [DW-1:0]      rdata_r;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr, load_addr, rd_addr;
  logic signed [DW-1:0]      mem_wdata;

  logic signed [DW-1:0]      acc_r, mt_r, term_r;
  logic                      neg_r;
  logic [63:0]               lo_r;
  logic [47:0]               hi_r;
  logic signed [58:0]        term_prod_r;
  logic [DW-1:0]             mag;
  logic signed [10:0]        fac_s;
  logic [49:0]               r50;
  logic signed [DW-1:0]      mt_val;

  logic [TW-1:0]             dur_sel, dur_sum_sel;
  logic [TW:0]               sum33, sst33;

  assign status.opcode   = op_r;
  assign status.n        = (coeff_count_r > pps_pkg::CNT_W'(pps_pkg::MAX_COEFFS))
                           ? pps_pkg::CNT_W'(pps_pkg::MAX_COEFFS) : coeff_count_r;
  assign status.ns       = (segment_count_r > pps_pkg::NSEG_W'(pps_pkg::MAX_SEGMENTS))
                           ? pps_pkg::NSEG_W'(pps_pkg::MAX_SEGMENTS) : segment_count_r;
  assign status.tracking = tracking_r;
  assign status.out_busy = out_valid && !out_ready;

  // configuration registers, written whenever a config write arrives (cfg_valid)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_count_r   <= pps_pkg::CNT_W'(pps_pkg::MAX_COEFFS);
      segment_count_r <= pps_pkg::NSEG_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == pps_pkg::CFG_COEFF_COUNT)
        coeff_count_r <= cfg_data[pps_pkg::CNT_W-1:0];
      else if (cfg_index == pps_pkg::CFG_SEGMENT_COUNT)
        segment_count_r <= cfg_data[pps_pkg::NSEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r    <= in_opcode;
      seg_r   <= in_segment;
      ax_in_r <= in_axis;
      ci_r    <= in_coeff_index;
      cv_r    <= in_coeff_value;
      tv_r    <= in_time_value;
    end
  end

  // coefficient memory: row (segment, axis) of MAX_COEFFS words
  assign load_addr = AW'(seg_r) * AW'(pps_pkg::AXES * pps_pkg::MAX_COEFFS)
                   + AW'(ax_in_r) * AW'(pps_pkg::MAX_COEFFS) + AW'(ci_r);
  assign rd_addr   = AW'(cur_r) * AW'(pps_pkg::AXES * pps_pkg::MAX_COEFFS)
                   + AW'(cmd.axis) * AW'(pps_pkg::MAX_COEFFS)
                   + AW'(cmd.k) + AW'(cmd.d);
  assign mem_we    = cmd.clr_we || (cmd.load_coeff
                     && (ci_r < pps_pkg::CNT_W'(pps_pkg::MAX_COEFFS))
                     && ({1'b0, seg_r} < (pps_pkg::SEG_W+1)'(pps_pkg::MAX_SEGMENTS)));
  assign mem_waddr = cmd.clr_we ? cmd.clr_addr : load_addr;
  assign mem_wdata = cmd.clr_we ? '0 : cv_r;

  always_ff @(posedge clk) begin
    if (mem_we) coef_mem[mem_waddr] <= mem_wdata;
    if (cmd.rd_issue) rdata_r <= coef_mem[rd_addr];
  end

  // durations, end time and segment pointer
  assign dur_sel     = dur_r[cur_r];
  assign dur_sum_sel = dur_r[cmd.idx];
  assign sum33       = {1'b0, sum_r} + {1'b0, dur_sum_sel};
  assign sst33       = {1'b0, sst_r} + {1'b0, dur_sel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pps_pkg::MAX_SEGMENTS; i++) dur_r[i] <= '0;
      end_time_r <= '0;
      sst_r      <= '0;
      cur_r      <= '0;
      tracking_r <= 1'b0;
    end else begin
      if (cmd.load_dur && ({1'b0, seg_r} < (pps_pkg::SEG_W+1)'(pps_pkg::MAX_SEGMENTS)))
        dur_r[seg_r] <= tv_r;
      if (cmd.sum_done) begin
        end_time_r <= sum_r;
        sst_r      <= '0;
        cur_r      <= '0;
      end
      if (cmd.setup) tracking_r <= (tv_r < end_time_r);
      // at most one segment step per sample
      if (cmd.advance && tracking_r && (t_r > dur_sel)
          && (cur_r != pps_pkg::SEG_W'(pps_pkg::MAX_SEGMENTS - 1))) begin
        sst_r <= sst33[TW] ? '1 : sst33[TW-1:0];
        cur_r <= cur_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_clear) sum_r <= '0;
    else if (cmd.sum_add) sum_r <= sum33[TW] ? '1 : sum33[TW-1:0];
    if (cmd.setup) t_r <= (tv_r >= sst_r) ? tv_r - sst_r : '0;
    else if (cmd.advance && tracking_r && (t_r > dur_sel)
             && (cur_r != pps_pkg::SEG_W'(pps_pkg::MAX_SEGMENTS - 1)))
      t_r <= t_r - dur_sel;
  end

  // horner step: multiply, scale and saturate, then accumulate
  assign mag   = acc_r[DW-1] ? (DW'(0) - DW'(acc_r)) : DW'(acc_r);
  assign fac_s = signed'({1'b0, pps_pkg::deriv_factor(cmd.k, cmd.d)});
  assign r50   = (hi_r[47:31] != '0) ? 50'h0_8000_0000_0000
               : (50'(hi_r) << 16) + 50'(lo_r[63:16]);
  always_comb begin
    if (neg_r) begin
      mt_val = (r50 >= 50'h0_8000_0000_0000) ? pps_pkg::NEG_MIN : DW'(50'd0 - r50);
    end else begin
      mt_val = (r50 > 50'(pps_pkg::POS_MAX)) ? pps_pkg::POS_MAX : signed'(r50[DW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      neg_r       <= acc_r[DW-1];
      lo_r        <= {32'd0, mag[31:0]} * {32'd0, t_r};
      hi_r        <= 48'(mag[47:32]) * 48'(t_r);
      term_prod_r <= 59'(rdata_r) * 59'(fac_s);
    end
    if (cmd.mt) begin
      mt_r   <= mt_val;
      term_r <= pps_pkg::sat48(64'(term_prod_r));
    end
    if (cmd.acc_clear) acc_r <= '0;
    else if (cmd.add) acc_r <= pps_pkg::sat48(64'(mt_r) + 64'(term_r));
    if (cmd.store_deriv) res_r[cmd.d] <= acc_r;
  end

  // result register and held positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      for (int i = 0; i < pps_pkg::AXES; i++) held_r[i] <= '0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
      if (tracking_r) held_r[cmd.axis] <= res_r[0];
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_axis        <= cmd.axis;
      out_tracking    <= tracking_r;
      out_last_of_run <= (cmd.axis == pps_pkg::YAW_AXIS);
      if (tracking_r) begin
        out_position     <= res_r[0];
        out_velocity     <= res_r[1];
        out_acceleration <= (cmd.axis == pps_pkg::YAW_AXIS) ? '0 : res_r[2];
        out_jerk_value   <= (cmd.axis == pps_pkg::YAW_AXIS) ? '0 : res_r[3];
      end else begin
        out_position     <= held_r[cmd.axis];
        out_velocity     <= '0;
        out_acceleration <= '0;
        out_jerk_value   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/piecewise_poly_trajectory_sampler_unit.sv =====
// Piecewise polynomial trajectory sampler, top level.
// Channels: in_* (valid/ready) carries load coefficient, load duration, start
// and sample requests; out_* (valid/ready) returns four results per sample,
// axes x, y, z, yaw in order, out_last_of_run set on yaw; cfg_* (valid/ready,
// always ready) writes coeff_count (index 0) and segment_count (index 1).
// A start sums the duration registers of the first segment_count segments
// sequentially. A sample evaluates each derivative with n coefficients on one
// shared horner unit, one coefficient at a time (memory read, multiply, scale,
// accumulate). A sample past the end time skips the horner steps.
// After reset the coefficient memory is cleared, all 640 words, during which
// in_ready stays low; config writes are taken throughout.
// A result waits in the output register while out_ready is low; the block
// stalls before the next result but takes a new request once the yaw result
// sits in the output register.
// Depends on pps_pkg, pps_ctrl and pps_datapath.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_poly_trajectory_sampler_unit (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        in_valid,
  output logic                                       in_ready,
  input  wire  [1:0]                                 in_opcode,
  input  wire  [pps_pkg::SEG_W-1:0]                  in_segment,
  input  wire  [1:0]                                 in_axis,
  input  wire  [pps_pkg::CNT_W-1:0]                  in_coeff_index,
  input  wire  signed [pps_pkg::DATA_W-1:0]          in_coeff_value,
  input  wire  [pps_pkg::TIME_W-1:0]                 in_time_value,
  output logic                                       out_valid,
  input  wire                                        out_ready,
  output logic [1:0]                                 out_axis,
  output logic signed [pps_pkg::DATA_W-1:0]          out_position,
  output logic signed [pps_pkg::DATA_W-1:0]          out_velocity,
  output logic signed [pps_pkg::DATA_W-1:0]          out_acceleration,
  output logic signed [pps_pkg::DATA_W-1:0]          out_jerk_value,
  output logic                                       out_tracking,
  output logic                                       out_last_of_run,
  input  wire                                        cfg_valid,
  output logic                                       cfg_ready,
  input  wire  [pps_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  wire  [pps_pkg::CFG_DATA_W-1:0]             cfg_data
);

  pps_pkg::pps_cmd_t    cmd;
  pps_pkg::pps_status_t status;

  assign cfg_ready = 1'b1;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pps_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_opcode        (in_opcode),
    .in_segment       (in_segment),
    .in_axis          (in_axis),
    .in_coeff_index   (in_coeff_index),
    .in_coeff_value   (in_coeff_value),
    .in_time_value    (in_time_value),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_axis         (out_axis),
    .out_position     (out_position),
    .out_velocity     (out_velocity),
    .out_acceleration (out_acceleration),
    .out_jerk_value   (out_jerk_value),
    .out_tracking     (out_tracking),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

`default_nettype wire
